// File: rtl/cfch_pkg.sv
// ----------------------------------------------------------------------------
// cfch_pkg
// Shared types, constants and helper functions for the combined
// FNV / rotate / CRC-like digest block.
// ----------------------------------------------------------------------------
package cfch_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam word_t FNV_SEED  = 32'h811C_9DC5;
  localparam word_t FNV_PRIME = 32'h0100_0193;
  localparam word_t CRC_POLY  = 32'hEDB8_8320;

  // One digest as produced on the last byte of a message
  typedef struct packed {
    word_t word_fnv;
    word_t word_rotsum;
    word_t word_crcish;
    word_t word_rotxor;
    word_t word_mix_a;
    word_t word_mix_b;
    word_t word_length;
    word_t word_mix_c;
  } digest_t;

  // Multiply by the FNV prime (bits 24, 8, 7, 4, 1, 0) as shift-adds, mod 2^32
  function automatic word_t fnv_mul(input word_t x);
    fnv_mul = x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  function automatic word_t rotl1(input word_t x);
    rotl1 = {x[WORD_W-2:0], x[WORD_W-1]};
  endfunction

  function automatic word_t rotl3(input word_t x);
    rotl3 = {x[WORD_W-4:0], x[WORD_W-1:WORD_W-3]};
  endfunction

endpackage

// File: rtl/cfch_if.sv
// ----------------------------------------------------------------------------
// cfch_if
// Valid/ready channel interfaces: message bytes in, digests out.
// ----------------------------------------------------------------------------
interface cfch_byte_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfch_digest_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          word_fnv;
  logic [31:0]          word_rotsum;
  logic [31:0]          word_crcish;
  logic [31:0]          word_rotxor;
  logic [31:0]          word_mix_a;
  logic [31:0]          word_mix_b;
  logic [31:0]          word_length;
  logic [31:0]          word_mix_c;

  modport source (output valid, output word_fnv, output word_rotsum,
                  output word_crcish, output word_rotxor, output word_mix_a,
                  output word_mix_b, output word_length, output word_mix_c,
                  input ready);
  modport sink   (input valid, input word_fnv, input word_rotsum,
                  input word_crcish, input word_rotxor, input word_mix_a,
                  input word_mix_b, input word_length, input word_mix_c,
                  output ready);
endinterface

// File: rtl/cfch_acc.sv
// ----------------------------------------------------------------------------
// cfch_acc
// Accumulator bank: folds one byte per step into the four hashes and the
// byte count, and presents the digest built from the updated values.
// ----------------------------------------------------------------------------
module cfch_acc (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cfch_pkg::byte_t  data_byte,
  input  logic             last_byte,
  output cfch_pkg::digest_t digest
);
  import cfch_pkg::*;

  word_t fnv_acc;
  word_t rotsum_acc;
  word_t crcish_acc;
  word_t rotxor_acc;
  word_t byte_count;

  word_t fnv_next;
  word_t rotsum_next;
  word_t crcish_next;
  word_t rotxor_next;
  word_t byte_count_next;
  word_t byte_ext;

  // Fold the byte into every accumulator
  always_comb begin
    byte_ext        = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
    fnv_next        = fnv_mul(fnv_acc ^ byte_ext);
    rotsum_next     = rotl1(rotsum_acc + byte_ext);
    crcish_next     = (crcish_acc >> 1) ^ (crcish_acc[0] ? CRC_POLY : '0) ^ byte_ext;
    rotxor_next     = rotl3(rotxor_acc ^ byte_ext);
    byte_count_next = byte_count + word_t'(1);
  end

  // Build the digest from the updated values
  always_comb begin
    digest.word_fnv    = fnv_next;
    digest.word_rotsum = rotsum_next;
    digest.word_crcish = crcish_next;
    digest.word_rotxor = rotxor_next;
    digest.word_mix_a  = fnv_next ^ rotsum_next;
    digest.word_mix_b  = crcish_next ^ rotxor_next;
    digest.word_length = byte_count_next;
    digest.word_mix_c  = fnv_next ^ crcish_next;
  end

  // Advance on each byte; return to seed values after the last one
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      fnv_acc    <= FNV_SEED;
      rotsum_acc <= '0;
      crcish_acc <= '0;
      rotxor_acc <= '0;
      byte_count <= '0;
    end else if (step) begin
      fnv_acc    <= fnv_next;
      rotsum_acc <= rotsum_next;
      crcish_acc <= crcish_next;
      rotxor_acc <= rotxor_next;
      byte_count <= byte_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> fnv_acc == FNV_SEED && byte_count == '0 && rotsum_acc == '0)
    else $error("accumulators not restarted after last byte");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    step && !last_byte |=> byte_count == $past(byte_count) + word_t'(1))
    else $error("byte count did not advance");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(fnv_acc) && $stable(crcish_acc) && $stable(byte_count))
    else $error("accumulators changed without a byte");
`endif

endmodule

// File: rtl/combined_fnv_rotate_crc_hash_core.sv
// ----------------------------------------------------------------------------
// combined_fnv_rotate_crc_hash_core
// Streaming digest of a byte message: FNV-1a, rotating sum, one-bit CRC-like
// step and rotate-xor, emitted as eight 32-bit words on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : one request per message byte (data_byte, last_byte). The byte
//            flagged last closes the message.
//   digest : one request per message, carrying the eight digest words.
//   A byte accepted from msg sits in the input register and is folded into
//   the accumulators when it leaves that register; for a last byte the
//   digest is loaded into the output register at that same edge, which
//   raises digest.valid. Throughput is one byte per cycle while no last byte
//   waits on a full output register; the only loop is the accumulator update
//   (FNV prime multiply as shift-adds) between input and accumulator
//   registers. Messages follow each other with no gap.
//   Reset (rst, synchronous) empties both registers and loads the seed
//   values. When the receiver holds digest.ready low, the waiting digest
//   stays put; ordinary bytes keep flowing, and only a further last byte
//   waits in the input register until the output register frees.
// ----------------------------------------------------------------------------
module combined_fnv_rotate_crc_hash_core (
  input  logic         clk,
  input  logic         rst,
  cfch_byte_if.sink    msg,
  cfch_digest_if.source digest
);
  import cfch_pkg::*;

  // Input register
  logic    stage_valid;
  byte_t   stage_byte;
  logic    stage_last;

  // Output register
  logic    out_valid;
  digest_t out_data;

  digest_t acc_digest;
  logic    out_free;
  logic    stage_adv;

  assign out_free  = !out_valid || digest.ready;
  assign stage_adv = stage_valid && (!stage_last || out_free);
  assign msg.ready = !stage_valid || stage_adv;

  // Hold the request until the accumulators take it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (msg.ready) begin
      stage_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      stage_byte <= msg.data_byte;
      stage_last <= msg.last_byte;
    end
  end

  cfch_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .step      (stage_adv),
    .data_byte (stage_byte),
    .last_byte (stage_last),
    .digest    (acc_digest)
  );

  // Load the digest on the last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && stage_last) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_last) begin
      out_data <= acc_digest;
    end
  end

  assign digest.valid       = out_valid;
  assign digest.word_fnv    = out_data.word_fnv;
  assign digest.word_rotsum = out_data.word_rotsum;
  assign digest.word_crcish = out_data.word_crcish;
  assign digest.word_rotxor = out_data.word_rotxor;
  assign digest.word_mix_a  = out_data.word_mix_a;
  assign digest.word_mix_b  = out_data.word_mix_b;
  assign digest.word_length = out_data.word_length;
  assign digest.word_mix_c  = out_data.word_mix_c;

`ifndef ASSERT_OFF
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_adv |=> stage_valid && $stable(stage_byte) && $stable(stage_last))
    else $error("stalled byte lost from input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !digest.ready |-> !(stage_adv && stage_last))
    else $error("waiting digest overwritten");

  a_mix_a: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.word_mix_a == (out_data.word_fnv ^ out_data.word_rotsum))
    else $error("mix word a inconsistent");

  a_mix_c: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.word_mix_c == (out_data.word_fnv ^ out_data.word_crcish))
    else $error("mix word c inconsistent");
`endif

endmodule
